>>> rtl/sbae_pkg.sv
`timescale 1ns / 1ps

package sbae_pkg;

	// register map, index = paddr / 4
	typedef enum logic [1:0] {
		REG_BRUSH_SIZE = 2'd0,
		REG_OPACITY    = 2'd1,
		REG_HARDNESS   = 2'd2
	} reg_idx_t;

	localparam logic [15:0] RST_BRUSH_SIZE = 16'd160;
	localparam logic [15:0] RST_OPACITY    = 16'd65535;
	localparam logic [15:0] RST_HARDNESS   = 16'd32768;

	// Q1.16 one and the hardness clamp (0.9999)
	localparam logic [16:0] ONE_Q16  = 17'd65536;
	localparam logic [15:0] HARD_MAX = 16'd65529;
	// 3.0 in Q.16 for the smoothstep polynomial
	localparam logic [17:0] THREE_Q16 = 18'd196608;

	// normalized distance squared (Q0.32) and its root (Q0.16)
	localparam int Q_BITS = 32;
	localparam int R_BITS = 16;

	// sideband that rides along every stage of the chain
	typedef struct packed {
		logic        touched;
		logic [7:0]  old_alpha;
		logic [15:0] erase;
	} side_t;

	localparam int SIDE_W = $bits(side_t);

endpackage

>>> rtl/sbae_div_cell.sv
`timescale 1ns / 1ps

// One restoring division step: produces one quotient bit per cell.
module sbae_div_cell #(
	parameter int DW = 17,
	parameter int QW = 16,
	parameter int SW = 25
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          up_valid,
	input  logic [DW-1:0] up_rem,
	input  logic [DW-1:0] up_dvs,
	input  logic [QW-1:0] up_quot,
	input  logic [SW-1:0] up_side,
	output logic          dn_valid,
	output logic [DW-1:0] dn_rem,
	output logic [DW-1:0] dn_dvs,
	output logic [QW-1:0] dn_quot,
	output logic [SW-1:0] dn_side
);

	logic [DW:0]   wide;
	logic [DW:0]   diff;
	logic          ge;
	logic [DW-1:0] rem_n;

	logic          valid_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] dvs_q;
	logic [QW-1:0] quot_q;
	logic [SW-1:0] side_q;

	// shift in a zero, subtract the divisor when it fits
	always_comb begin
		wide  = {up_rem, 1'b0};
		diff  = wide - {1'b0, up_dvs};
		ge    = (wide >= {1'b0, up_dvs});
		rem_n = ge ? diff[DW-1:0] : wide[DW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= rem_n;
			dvs_q  <= up_dvs;
			quot_q <= {up_quot[QW-2:0], ge};
			side_q <= up_side;
		end
	end

	assign dn_valid = valid_q;
	assign dn_rem   = rem_q;
	assign dn_dvs   = dvs_q;
	assign dn_quot  = quot_q;
	assign dn_side  = side_q;

endmodule

>>> rtl/sbae_sqrt_cell.sv
`timescale 1ns / 1ps

// One digit-by-digit square root step: consumes two radicand bits,
// produces one root bit.
module sbae_sqrt_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       up_valid,
	input  logic [sbae_pkg::Q_BITS-1:0] up_rad,
	input  logic [sbae_pkg::R_BITS:0]   up_rem,
	input  logic [sbae_pkg::R_BITS-1:0] up_root,
	input  logic [sbae_pkg::SIDE_W-1:0] up_side,
	output logic                       dn_valid,
	output logic [sbae_pkg::Q_BITS-1:0] dn_rad,
	output logic [sbae_pkg::R_BITS:0]   dn_rem,
	output logic [sbae_pkg::R_BITS-1:0] dn_root,
	output logic [sbae_pkg::SIDE_W-1:0] dn_side
);

	import sbae_pkg::*;

	logic [R_BITS+1:0] cur;
	logic [R_BITS+1:0] trial;
	logic [R_BITS+1:0] diff;
	logic              ge;

	logic              valid_q;
	logic [Q_BITS-1:0] rad_q;
	logic [R_BITS:0]   rem_q;
	logic [R_BITS-1:0] root_q;
	logic [SIDE_W-1:0] side_q;

	// bring down two bits, try root*4+1
	always_comb begin
		cur   = {up_rem[R_BITS-1:0], up_rad[Q_BITS-1 -: 2]};
		trial = {up_root, 2'b01};
		diff  = cur - trial;
		ge    = (cur >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_q  <= {up_rad[Q_BITS-3:0], 2'b00};
			rem_q  <= ge ? diff[R_BITS:0] : cur[R_BITS:0];
			root_q <= {up_root[R_BITS-2:0], ge};
			side_q <= up_side;
		end
	end

	assign dn_valid = valid_q;
	assign dn_rad   = rad_q;
	assign dn_rem   = rem_q;
	assign dn_root  = root_q;
	assign dn_side  = side_q;

endmodule

>>> rtl/soft_brush_alpha_erase.sv
// Throughput: one pixel per cycle while the skid register is empty; then the chain
// of 32 division, 16 root and 16 falloff division cells moves one step per cycle.
// A stalled result moves into a skid register; input stalls only while it is full.
// Reset (arst_n low, asynchronous) clears all valid bits and loads the
// registers with brush_size 160, opacity 65535, hardness 32768.
`timescale 1ns / 1ps

module soft_brush_alpha_erase #(
	parameter int COORD_FRAC_BITS  = 8,
	parameter int PIXEL_COORD_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	// APB configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// pixel requests
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [15:0]        pixel_x,
	input  logic [15:0]        pixel_y,
	input  logic signed [23:0] dab_x,
	input  logic signed [23:0] dab_y,
	input  logic [15:0]        pressure,
	input  logic [7:0]         old_alpha,
	// results
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         new_alpha,
	output logic               touched
);

	import sbae_pkg::*;

	localparam int F    = COORD_FRAC_BITS;
	localparam int PB   = PIXEL_COORD_BITS;
	localparam int RADW = 32 - (21 - F);
	localparam int R2W  = 2 * RADW;
	localparam int PXW  = PB + F;
	localparam int DXW  = ((PXW > 23) ? PXW : 23) + 2;
	localparam int AW   = DXW - 1;
	localparam int D2W  = 2 * AW + 1;
	localparam int CW   = (D2W > R2W) ? D2W : R2W;
	localparam int NDIV = Q_BITS;
	localparam int NSQ  = R_BITS;
	localparam int NT   = R_BITS;

	logic en;

	//--------------------------------------------------------------------
	// configuration registers
	//--------------------------------------------------------------------
	logic [15:0] brush_size_q;
	logic [15:0] opacity_q;
	logic [15:0] hardness_q;
	reg_idx_t    cfg_idx;

	assign cfg_idx = reg_idx_t'(paddr[3:2]);
	assign pready  = 1'b1;

	// write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brush_size_q <= RST_BRUSH_SIZE;
			opacity_q    <= RST_OPACITY;
			hardness_q   <= RST_HARDNESS;
		end else if (psel && penable && pwrite) begin
			unique case (cfg_idx)
				REG_BRUSH_SIZE: brush_size_q <= pwdata[15:0];
				REG_OPACITY:    opacity_q    <= pwdata[15:0];
				REG_HARDNESS:   hardness_q   <= pwdata[15:0];
				default:        ;
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (cfg_idx)
			REG_BRUSH_SIZE: prdata = {16'd0, brush_size_q};
			REG_OPACITY:    prdata = {16'd0, opacity_q};
			REG_HARDNESS:   prdata = {16'd0, hardness_q};
			default:        prdata = 32'd0;
		endcase
	end

	//--------------------------------------------------------------------
	// stage 1: diameter product, erase strength, distances
	//--------------------------------------------------------------------
	logic signed [DXW-1:0] px_c, py_c, dx_c, dy_c;
	logic [32:0]           ep_c;

	logic          valid_s1;
	logic [31:0]   prod_s1;
	logic [15:0]   erase_s1;
	logic [AW-1:0] ax_s1, ay_s1;
	logic [7:0]    old_s1;

	always_comb begin
		px_c = signed'(DXW'({pixel_x[PB-1:0], {F{1'b0}}}));
		py_c = signed'(DXW'({pixel_y[PB-1:0], {F{1'b0}}}));
		dx_c = px_c - DXW'(dab_x);
		dy_c = py_c - DXW'(dab_y);
		ep_c = 33'(32'(opacity_q) * 32'(pressure)) + 33'd32768;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1  <= brush_size_q * pressure;
			erase_s1 <= ep_c[31:16];
			ax_s1    <= dx_c[DXW-1] ? AW'(-dx_c) : AW'(dx_c);
			ay_s1    <= dy_c[DXW-1] ? AW'(-dy_c) : AW'(dy_c);
			old_s1   <= old_alpha;
		end
	end

	//--------------------------------------------------------------------
	// stage 2: squares
	//--------------------------------------------------------------------
	logic             valid_s2;
	logic [R2W-1:0]   r2_s2;
	logic [2*AW-1:0]  ax2_s2, ay2_s2;
	logic             small_s2;
	logic [15:0]      erase_s2;
	logic [7:0]       old_s2;
	logic [RADW-1:0]  rad_c;

	assign rad_c = prod_s1[31 -: RADW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r2_s2    <= rad_c * rad_c;
			ax2_s2   <= ax_s1 * ax_s1;
			ay2_s2   <= ay_s1 * ay_s1;
			small_s2 <= (prod_s1[31:20] == 12'd0);
			erase_s2 <= erase_s1;
			old_s2   <= old_s1;
		end
	end

	//--------------------------------------------------------------------
	// stage 3: distance sum and inside test
	//--------------------------------------------------------------------
	logic [D2W-1:0] d2_c;
	logic           in_c;
	logic           valid_s3;
	logic [R2W-1:0] rem_s3;
	logic [R2W-1:0] r2_s3;
	side_t          side_s3;

	always_comb begin
		d2_c = {1'b0, ax2_s2} + {1'b0, ay2_s2};
		in_c = !small_s2 && (r2_s2 != '0) && (CW'(d2_c) < CW'(r2_s2));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s3            <= in_c ? R2W'(d2_c) : '0;
			r2_s3             <= r2_s2;
			side_s3.touched   <= in_c;
			side_s3.old_alpha <= old_s2;
			side_s3.erase     <= erase_s2;
		end
	end

	//--------------------------------------------------------------------
	// d2 / r2 as a Q0.32 fraction, one bit per cell
	//--------------------------------------------------------------------
	logic              dv_valid [0:NDIV];
	logic [R2W-1:0]    dv_rem   [0:NDIV];
	logic [R2W-1:0]    dv_dvs   [0:NDIV];
	logic [Q_BITS-1:0] dv_quot  [0:NDIV];
	logic [SIDE_W-1:0] dv_side  [0:NDIV];

	assign dv_valid[0] = valid_s3;
	assign dv_rem[0]   = rem_s3;
	assign dv_dvs[0]   = r2_s3;
	assign dv_quot[0]  = '0;
	assign dv_side[0]  = side_s3;

	for (genvar i = 0; i < NDIV; i++) begin : g_div
		sbae_div_cell #(.DW(R2W), .QW(Q_BITS), .SW(SIDE_W)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.up_valid (dv_valid[i]),
			.up_rem   (dv_rem[i]),
			.up_dvs   (dv_dvs[i]),
			.up_quot  (dv_quot[i]),
			.up_side  (dv_side[i]),
			.dn_valid (dv_valid[i+1]),
			.dn_rem   (dv_rem[i+1]),
			.dn_dvs   (dv_dvs[i+1]),
			.dn_quot  (dv_quot[i+1]),
			.dn_side  (dv_side[i+1])
		);
	end

	//--------------------------------------------------------------------
	// square root of the fraction, one root bit per cell
	//--------------------------------------------------------------------
	logic              sq_valid [0:NSQ];
	logic [Q_BITS-1:0] sq_rad   [0:NSQ];
	logic [R_BITS:0]   sq_rem   [0:NSQ];
	logic [R_BITS-1:0] sq_root  [0:NSQ];
	logic [SIDE_W-1:0] sq_side  [0:NSQ];

	assign sq_valid[0] = dv_valid[NDIV];
	assign sq_rad[0]   = dv_quot[NDIV];
	assign sq_rem[0]   = '0;
	assign sq_root[0]  = '0;
	assign sq_side[0]  = dv_side[NDIV];

	for (genvar i = 0; i < NSQ; i++) begin : g_sqrt
		sbae_sqrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.up_valid (sq_valid[i]),
			.up_rad   (sq_rad[i]),
			.up_rem   (sq_rem[i]),
			.up_root  (sq_root[i]),
			.up_side  (sq_side[i]),
			.dn_valid (sq_valid[i+1]),
			.dn_rad   (sq_rad[i+1]),
			.dn_rem   (sq_rem[i+1]),
			.dn_root  (sq_root[i+1]),
			.dn_side  (sq_side[i+1])
		);
	end

	//--------------------------------------------------------------------
	// stage 4: distance beyond the hard core; inside the core t becomes 0
	//--------------------------------------------------------------------
	logic [15:0]       h_c;
	logic [R_BITS-1:0] r_c;
	logic              valid_s4;
	logic [16:0]       dvd_s4;
	logic [16:0]       dvs_s4;
	logic [SIDE_W-1:0] side_s4;

	always_comb begin
		h_c = (hardness_q > HARD_MAX) ? HARD_MAX : hardness_q;
		r_c = sq_root[NSQ];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= sq_valid[NSQ];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dvd_s4  <= (r_c > h_c) ? {1'b0, r_c - h_c} : 17'd0;
			dvs_s4  <= ONE_Q16 - {1'b0, h_c};
			side_s4 <= sq_side[NSQ];
		end
	end

	//--------------------------------------------------------------------
	// t = (r - h) / (1 - h), one bit per cell
	//--------------------------------------------------------------------
	logic              tv_valid [0:NT];
	logic [16:0]       tv_rem   [0:NT];
	logic [16:0]       tv_dvs   [0:NT];
	logic [R_BITS-1:0] tv_quot  [0:NT];
	logic [SIDE_W-1:0] tv_side  [0:NT];

	assign tv_valid[0] = valid_s4;
	assign tv_rem[0]   = dvd_s4;
	assign tv_dvs[0]   = dvs_s4;
	assign tv_quot[0]  = '0;
	assign tv_side[0]  = side_s4;

	for (genvar i = 0; i < NT; i++) begin : g_tdiv
		sbae_div_cell #(.DW(17), .QW(R_BITS), .SW(SIDE_W)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.up_valid (tv_valid[i]),
			.up_rem   (tv_rem[i]),
			.up_dvs   (tv_dvs[i]),
			.up_quot  (tv_quot[i]),
			.up_side  (tv_side[i]),
			.dn_valid (tv_valid[i+1]),
			.dn_rem   (tv_rem[i+1]),
			.dn_dvs   (tv_dvs[i+1]),
			.dn_quot  (tv_quot[i+1]),
			.dn_side  (tv_side[i+1])
		);
	end

	//--------------------------------------------------------------------
	// stages 5..9: smoothstep, coverage, alpha scaling
	//--------------------------------------------------------------------
	logic        valid_s5, valid_s6, valid_s7, valid_s8, valid_s9;
	logic [31:0] tt_s5;
	logic [17:0] w_s5;
	side_t       side_s5, side_s6, side_s7, side_s8;
	logic [49:0] x_s6;
	logic [32:0] ae_s7;
	logic [24:0] of_s8;
	logic [7:0]  alpha_s9;
	logic        touched_s9;

	logic [50:0] xs_c;
	logic [16:0] a_c;
	logic [33:0] fr_c;
	logic [16:0] f_c;
	logic [25:0] ar_c;
	side_t       tside_c;

	always_comb begin
		tside_c = side_t'(tv_side[NT]);
		xs_c    = {1'b0, x_s6} + 51'h0_8000_0000;
		a_c     = (xs_c[50:32] >= 19'(ONE_Q16)) ? 17'd0 : ONE_Q16 - xs_c[48:32];
		fr_c    = {1'b0, ae_s7} + 34'd32768;
		f_c     = (fr_c[33:16] >= 18'(ONE_Q16)) ? 17'd0 : ONE_Q16 - fr_c[32:16];
		ar_c    = {1'b0, of_s8} + 26'd32768;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
			valid_s9 <= 1'b0;
		end else if (en) begin
			valid_s5 <= tv_valid[NT];
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
			valid_s9 <= valid_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// t^2 and (3 - 2t)
			tt_s5      <= tv_quot[NT] * tv_quot[NT];
			w_s5       <= THREE_Q16 - {1'b0, tv_quot[NT], 1'b0};
			side_s5    <= tside_c;
			// t^2 * (3 - 2t)
			x_s6       <= tt_s5 * w_s5;
			side_s6    <= side_s5;
			// coverage times erase strength
			ae_s7      <= a_c * side_s6.erase;
			side_s7    <= side_s6;
			// alpha times the remaining factor
			of_s8      <= side_s7.old_alpha * f_c;
			side_s8    <= side_s7;
			// round, or pass the old alpha outside the dab
			alpha_s9   <= side_s8.touched ? ar_c[23:16] : side_s8.old_alpha;
			touched_s9 <= side_s8.touched;
		end
	end

	//--------------------------------------------------------------------
	// output skid register
	//--------------------------------------------------------------------
	logic       skid_valid_q;
	logic [7:0] skid_alpha_q;
	logic       skid_touched_q;

	assign en = !skid_valid_q;

	// park a stalled result; the chain halts while the skid register is full
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_valid_q <= 1'b0;
		end else if (en) begin
			skid_valid_q <= valid_s9 && out_stall;
		end else if (!out_stall) begin
			skid_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			skid_alpha_q   <= alpha_s9;
			skid_touched_q <= touched_s9;
		end
	end

	assign in_stall  = skid_valid_q;
	assign out_valid = skid_valid_q || valid_s9;
	assign new_alpha = skid_valid_q ? skid_alpha_q : alpha_s9;
	assign touched   = skid_valid_q ? skid_touched_q : touched_s9;

endmodule

>>> tb/sv/tb_soft_brush_alpha_erase.sv
`timescale 1ns / 1ps

module tb_soft_brush_alpha_erase;
	import sbae_pkg::*;

	localparam int F = 8;
	localparam int LATENCY = 73;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int N_RANDOM = 1150;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		logic [15:0] px;
		logic [15:0] py;
		logic [23:0] cx;
		logic [23:0] cy;
		logic [15:0] pres;
		logic [7:0]  alpha;
	} pixel_req_t;

	typedef struct {
		logic [7:0] alpha;
		logic       hit;
	} erase_res_t;

	typedef struct {
		pixel_req_t req;
		bit         typed;
		logic [7:0] alpha;
		logic       hit;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [15:0] pixel_x = '0, pixel_y = '0, pressure = '0;
	logic signed [23:0] dab_x = '0, dab_y = '0;
	logic [7:0] old_alpha = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] new_alpha;
	logic touched;

	soft_brush_alpha_erase i_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.pixel_x(pixel_x), .pixel_y(pixel_y), .dab_x(dab_x), .dab_y(dab_y),
		.pressure(pressure), .old_alpha(old_alpha),
		.out_valid(out_valid), .out_stall(out_stall),
		.new_alpha(new_alpha), .touched(touched)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// register shadow for the predictor
	logic [15:0] cfg_size, cfg_opacity, cfg_hard;
	erase_res_t alpha_queue[$];
	int errors = 0;
	int n_sent = 0, n_hit = 0, n_got = 0;
	int idle_cycles = 0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;
	bit rand_out_idle = 1'b0;

	function automatic erase_res_t predict_erase(pixel_req_t q);
		erase_res_t res;
		logic [63:0] prod, rad, r2, ax, ay, d2, quo, rem, rt, h, a, e, fr, t, s;
		logic [63:0] v, bitv;
		longint signed dx, dy;
		res.alpha = q.alpha;
		res.hit = 1'b0;
		prod = 64'(cfg_size) * 64'(q.pres);
		if (prod < 64'd1048576) return res;
		rad = prod >> (21 - F);
		r2 = rad * rad;
		dx = (longint'(q.px) <<< F) - longint'($signed(q.cx));
		dy = (longint'(q.py) <<< F) - longint'($signed(q.cy));
		ax = dx < 0 ? -dx : dx;
		ay = dy < 0 ? -dy : dy;
		d2 = ax * ax + ay * ay;
		if (r2 == 0 || d2 >= r2) return res;
		quo = 0;
		rem = d2;
		for (int i = 0; i < 32; i++) begin
			rem = rem << 1;
			quo = quo << 1;
			if (rem >= r2) begin
				rem = rem - r2;
				quo = quo | 64'd1;
			end
		end
		// bitwise integer root
		v = quo;
		rt = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= rt + bitv) begin
				v = v - (rt + bitv);
				rt = (rt >> 1) + bitv;
			end else begin
				rt = rt >> 1;
			end
			bitv = bitv >> 2;
		end
		h = cfg_hard > HARD_MAX ? 64'(HARD_MAX) : 64'(cfg_hard);
		if (rt <= h) begin
			a = 64'd65536;
		end else begin
			t = ((rt - h) << 16) / (64'd65536 - h);
			s = (t * t * (64'd196608 - 2 * t) + (64'd1 << 31)) >> 32;
			a = s >= 64'd65536 ? 64'd0 : 64'd65536 - s;
		end
		e = (64'(cfg_opacity) * 64'(q.pres) + 64'd32768) >> 16;
		fr = (a * e + 64'd32768) >> 16;
		fr = fr >= 64'd65536 ? 64'd0 : 64'd65536 - fr;
		res.alpha = 8'((64'(q.alpha) * fr + 64'd32768) >> 16);
		res.hit = 1'b1;
		return res;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		errors++;
		$display("mismatch %s: got %0d, expected %0d (result %0d)", what, got, want, n_got);
	endtask

	// drive one request and hold it until accepted
	task automatic send_pixel(pixel_req_t q, bit typed, logic [7:0] ta, logic th);
		erase_res_t exp;
		int gap;
		exp = predict_erase(q);
		if (typed) begin
			exp.alpha = ta;
			exp.hit = th;
		end
		alpha_queue.push_back(exp);
		if (exp.hit) n_hit++;
		in_valid <= 1'b1;
		pixel_x <= q.px;
		pixel_y <= q.py;
		dab_x <= q.cx;
		dab_y <= q.cy;
		pressure <= q.pres;
		old_alpha <= q.alpha;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		n_sent++;
		gap = ($urandom_range(0, 3) == 0) ?
			(($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3)) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_reg(reg_idx_t idx, logic [15:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_BRUSH_SIZE: cfg_size = val;
			REG_OPACITY:    cfg_opacity = val;
			default:        cfg_hard = val;
		endcase
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (alpha_queue.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	// random pixel, most of them placed near the dab
	function automatic pixel_req_t rand_pixel();
		pixel_req_t q;
		int span;
		q.px = 16'($urandom);
		q.py = 16'($urandom);
		q.pres = 16'($urandom);
		q.alpha = 8'($urandom);
		if ($urandom_range(0, 9) < 8) begin
			span = int'((longint'(cfg_size) * longint'(q.pres)) >>> (21 - F));
			span = span + 512;
			q.cx = 24'((int'(q.px) <<< F) + $urandom_range(0, 2 * span) - span);
			q.cy = 24'((int'(q.py) <<< F) + $urandom_range(0, 2 * span) - span);
		end else begin
			q.cx = 24'($urandom);
			q.cy = 24'($urandom);
		end
		return q;
	endfunction

	// check results in order
	always @(posedge clk) begin
		erase_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (alpha_queue.size() == 0) begin
				errors++;
				$display("unexpected result: new_alpha %0d touched %0d", new_alpha, touched);
			end else begin
				want = alpha_queue.pop_front();
				if (new_alpha !== want.alpha) report_mismatch("new_alpha", new_alpha, want.alpha);
				if (touched !== want.hit) report_mismatch("touched", touched, want.hit);
			end
			n_got++;
		end
	end

	// receiver stalls: random short and long, plus one long hold-off counted here
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_done) begin
			out_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (rand_out_idle) begin
			if ($urandom_range(0, 60) == 0) begin
				out_stall <= 1'b1;
				hold_left <= $urandom_range(10, 40);
			end else begin
				out_stall <= ($urandom_range(0, 3) == 0);
			end
		end else begin
			out_stall <= 1'b0;
		end
	end

	// watchdog on stretches with no progress
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired, %0d results outstanding", alpha_queue.size());
			$display("** soft_brush_alpha_erase: FAILED **");
			$finish;
		end
	end

	dir_row_t dir_rows[$];

	task automatic add_row(logic [15:0] px, logic [15:0] py, logic [23:0] cx, logic [23:0] cy,
			logic [15:0] pr, logic [7:0] al, bit typed, logic [7:0] ta, logic th);
		dir_row_t row;
		row.req.px = px;
		row.req.py = py;
		row.req.cx = cx;
		row.req.cy = cy;
		row.req.pres = pr;
		row.req.alpha = al;
		row.typed = typed;
		row.alpha = ta;
		row.hit = th;
		dir_rows.push_back(row);
	endtask

	initial begin
		cfg_size = RST_BRUSH_SIZE;
		cfg_opacity = RST_OPACITY;
		cfg_hard = RST_HARDNESS;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows at reset settings (diameter 10 px)
		add_row(16'd5, 16'd5, 24'h000500, 24'h000500, 16'd0, 8'd200, 1, 8'd200, 0);
		add_row(16'd5, 16'd5, 24'h000500, 24'h000500, 16'd65535, 8'd255, 1, 8'd0, 1);
		add_row(16'd5, 16'd5, 24'h000500, 24'h000500, 16'd65535, 8'd0, 1, 8'd0, 1);
		add_row(16'd100, 16'd5, 24'h000500, 24'h000500, 16'd65535, 8'd77, 1, 8'd77, 0);
		add_row(16'hFFFF, 16'hFFFF, 24'h800000, 24'h7FFFFF, 16'd65535, 8'd9, 1, 8'd9, 0);
		add_row(16'd9, 16'd5, 24'h000500, 24'h000500, 16'd65535, 8'd255, 0, 0, 0);
		add_row(16'd5, 16'd1, 24'h000500, 24'h000500, 16'd65535, 8'd255, 0, 0, 0);
		add_row(16'd10, 16'd5, 24'h000500, 24'h000500, 16'd65535, 8'd255, 1, 8'd255, 0);
		add_row(16'd7, 16'd8, 24'h000580, 24'h000540, 16'd32768, 8'd128, 0, 0, 0);
		add_row(16'd0, 16'd0, 24'hFFFF80, 24'h000040, 16'd40000, 8'd255, 0, 0, 0);
		add_row(16'd3, 16'd3, 24'h000500, 24'h000500, 16'd6554, 8'd255, 0, 0, 0);
		add_row(16'd5, 16'd5, 24'h000500, 24'h000500, 16'd6553, 8'd255, 0, 0, 0);
		add_row(16'hFFFF, 16'hFFFF, 24'h7FFF00, 24'h7FFF00, 16'd65535, 8'd255, 0, 0, 0);
		add_row(16'hAAAA, 16'h5555, 24'h555555, 24'hAAAAAA, 16'hAAAA, 8'h55, 0, 0, 0);
		rand_out_idle = 1'b1;
		foreach (dir_rows[i])
			send_pixel(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].alpha, dir_rows[i].hit);
		drain();

		// phases over register settings, extremes included
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					write_reg(REG_BRUSH_SIZE, 16'hFFFF);
					write_reg(REG_OPACITY, 16'd0);
					write_reg(REG_HARDNESS, 16'hFFFF);
				end
				1: begin
					write_reg(REG_BRUSH_SIZE, 16'd0);
					write_reg(REG_OPACITY, 16'hFFFF);
					write_reg(REG_HARDNESS, 16'd0);
				end
				2: begin
					write_reg(REG_BRUSH_SIZE, 16'd16);
					write_reg(REG_HARDNESS, 16'd65529);
				end
				default: begin
					write_reg(REG_BRUSH_SIZE, 16'($urandom_range(8, 2000)));
					write_reg(REG_OPACITY, 16'($urandom));
					write_reg(REG_HARDNESS, 16'($urandom));
				end
			endcase
			rand_out_idle = (ph != 4);
			for (int k = 0; k < N_RANDOM / 6; k++) begin
				if (ph == 3 && k == 20) hold_req = 1'b1;
				send_pixel(rand_pixel(), 0, 0, 0);
			end
			drain();
		end

		$display("sent %0d pixels over 7 register settings, %0d inside the dab", n_sent, n_hit);
		$display("long output hold-off backed up the pipeline into input stalls");
		if (errors == 0 && alpha_queue.size() == 0) begin
			$display("** soft_brush_alpha_erase: PASSED **");
		end else begin
			$display("** soft_brush_alpha_erase: FAILED **");
		end
		$finish;
	end

endmodule
